### design/fbm_pkg.sv
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared types, codes and helpers for the file block mapper with table cache.
// ----------------------------------------------------------------------------
package fbm_pkg;

  localparam int TABLE_WORDS_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int DIRECT_POINTERS = 12;
  localparam int ROOT_COUNT      = DIRECT_POINTERS + 3;
  localparam int TABLE_SLOTS     = 6;
  localparam int IDX_W           = 10;

  localparam logic [1:0] ACT_MAP  = 2'd0;
  localparam logic [1:0] ACT_ROOT = 2'd1;
  localparam logic [1:0] ACT_FILL = 2'd2;

  localparam logic [1:0] ST_MAPPED = 2'd0;
  localparam logic [1:0] ST_HOLE   = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_FETCH  = 2'd3;

  localparam logic [1:0] CFG_BLOCK_SIZE_LOG = 2'd0;
  localparam logic [1:0] CFG_FILE_SIZE_LOW  = 2'd1;
  localparam logic [1:0] CFG_FILE_SIZE_HIGH = 2'd2;
  localparam logic [1:0] CFG_IS_DIRECTORY   = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      logical_block;
    logic [3:0]       pointer_slot;
    logic [2:0]       table_slot;
    logic [IDX_W-1:0] word_index;
    logic [31:0]      word_value;
    logic [31:0]      table_block;
    logic             fill_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_number;
    logic [2:0]  fetch_table_slot;
  } res_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ROOT,
    CMD_FILL,
    CMD_BEYOND,
    CMD_DIRECT,
    CMD_WALK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [3:0]             sel;
    logic [2:0]             base;
    logic [1:0]             levels;
    logic [2:0][IDX_W-1:0]  idx;
    logic [2:0]             table_slot;
    logic [IDX_W-1:0]       word_index;
    logic [31:0]            word_value;
    logic [31:0]            table_block;
    logic                   fill_last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_READ
  } bk_state_t;

  // block size code three behaves as code two
  function automatic logic [1:0] fbm_clamp_bsl(input logic [1:0] bsl);
    return (bsl == 2'd3) ? 2'd2 : bsl;
  endfunction

  // first logical block past the single, double or triple range
  function automatic logic [31:0] fbm_span_end(input logic [1:0] bsl, input logic [1:0] lvl);
    logic [4:0]  pl;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    pl = 5'd8 + {3'b000, bsl};
    t1 = 32'(DIRECT_POINTERS) + (32'd1 << pl);
    t2 = t1 + (32'd1 << (5'd2 * pl));
    t3 = t2 + (32'd1 << (5'd3 * pl));
    case (lvl)
      2'd0:    return t1;
      2'd1:    return t2;
      default: return t3;
    endcase
  endfunction

endpackage

### design/file_block_map_with_table_cache.sv
// ----------------------------------------------------------------------------
// file_block_map_with_table_cache
// Maps file logical blocks to disk blocks through root pointers and cached
// single, double and triple indirect tables.
//
//   channel   handshake              payload
//   in_       in_valid / in_stall    fbm_pkg::in_t   in_data
//   out_      out_valid / out_stall  fbm_pkg::res_t  out_data
//   cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// the classifier takes a transfer per cycle while the command queue has
// room and holds two stages before the queue; the walker executes root loads,
// fills and direct or beyond end requests straight from its idle state, and a
// table walk through a check and a read state per level and a final check,
// bound by one table store read per level. synchronous active low reset; the
// table store is not cleared. a stalled result holds the walker; the queue
// keeps the input side moving until it fills. TABLE_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module file_block_map_with_table_cache #(
  parameter int TABLE_WORDS = fbm_pkg::TABLE_WORDS_DEF,
  parameter int QUEUE_DEPTH = fbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fbm_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fbm_pkg::res_t   out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  logic            q_push;
  fbm_pkg::cmd_t   q_data;
  logic            q_full;
  logic            q_valid;
  fbm_pkg::cmd_t   q_head;
  logic            q_pop;

  fbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  fbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  fbm_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("command pushed into full queue");

  a_fetch_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fbm_pkg::ST_FETCH) |->
      (out_data.block_number != 32'd0) && (out_data.fetch_table_slot <= 3'd5))
    else $error("fetch result with zero block or bad slot");

  a_empty_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == fbm_pkg::ST_HOLE) ||
                  (out_data.status == fbm_pkg::ST_BEYOND)) |->
      (out_data.block_number == 32'd0) && (out_data.fetch_table_slot == 3'd0))
    else $error("hole or beyond end result carries a block");

  a_mapped_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == fbm_pkg::ST_MAPPED) |->
      (out_data.block_number != 32'd0) && (out_data.fetch_table_slot == 3'd0))
    else $error("mapped result with zero block");

endmodule

### design/fbm_front.sv
// ----------------------------------------------------------------------------
// fbm_front
// Configuration registers and a two stage classifier that turns input items
// into back end commands: end of file check, range decode and table indices.
// ----------------------------------------------------------------------------
module fbm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbm_pkg::in_t       in_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               q_push,
  output fbm_pkg::cmd_t      q_data,
  input  logic               q_full
);

  logic [1:0]  bsl_cfg_r;
  logic [31:0] size_low_r;
  logic [31:0] size_high_r;
  logic        is_dir_r;

  logic                  s1_v_r;
  fbm_pkg::in_t          s1_item_r;
  logic                  s2_v_r;
  fbm_pkg::in_t          s2_item_r;
  fbm_pkg::cmd_kind_t    s2_kind_r;
  logic [1:0]            s2_lvl_r;

  logic                  s1_en;
  logic                  s2_en;
  logic                  s2_done;

  logic [1:0]            bsl;
  logic [63:0]           fsize;
  logic [63:0]           fsize_m1;
  logic [63:0]           last_blk;
  logic [31:0]           nb1;
  fbm_pkg::cmd_kind_t    kind_c;
  logic [1:0]            lvl_c;

  logic [31:0]           base2;
  logic [31:0]           off;
  logic [31:0]           sh1;
  logic [31:0]           sh2;
  logic [9:0]            mask;
  fbm_pkg::cmd_t         cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_cfg_r   <= '0;
      size_low_r  <= '0;
      size_high_r <= '0;
      is_dir_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbm_pkg::CFG_BLOCK_SIZE_LOG: bsl_cfg_r   <= cfg_data[1:0];
        fbm_pkg::CFG_FILE_SIZE_LOW:  size_low_r  <= cfg_data;
        fbm_pkg::CFG_FILE_SIZE_HIGH: size_high_r <= cfg_data;
        fbm_pkg::CFG_IS_DIRECTORY:   is_dir_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s2_done  = (s2_kind_r == fbm_pkg::CMD_NONE) || !q_full;
  assign s2_en    = !s2_v_r || s2_done;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;
  assign q_push   = s2_v_r && (s2_kind_r != fbm_pkg::CMD_NONE) && !q_full;

  // stage one: end of file and range decode
  always_comb begin
    bsl      = fbm_pkg::fbm_clamp_bsl(bsl_cfg_r);
    fsize    = is_dir_r ? {32'd0, size_low_r} : {size_high_r, size_low_r};
    fsize_m1 = fsize - 64'd1;
    case (bsl)
      2'd0:    last_blk = fsize_m1 >> 10;
      2'd1:    last_blk = fsize_m1 >> 11;
      default: last_blk = fsize_m1 >> 12;
    endcase
    nb1    = s1_item_r.logical_block;
    kind_c = fbm_pkg::CMD_NONE;
    lvl_c  = 2'd0;
    case (s1_item_r.action)
      fbm_pkg::ACT_MAP: begin
        if ((fsize == 64'd0) || ({32'd0, nb1} > last_blk)) begin
          kind_c = fbm_pkg::CMD_BEYOND;
        end else if (nb1 < 32'(fbm_pkg::DIRECT_POINTERS)) begin
          kind_c = fbm_pkg::CMD_DIRECT;
        end else if (nb1 < fbm_pkg::fbm_span_end(bsl, 2'd0)) begin
          kind_c = fbm_pkg::CMD_WALK;
          lvl_c  = 2'd0;
        end else if (nb1 < fbm_pkg::fbm_span_end(bsl, 2'd1)) begin
          kind_c = fbm_pkg::CMD_WALK;
          lvl_c  = 2'd1;
        end else if (nb1 < fbm_pkg::fbm_span_end(bsl, 2'd2)) begin
          kind_c = fbm_pkg::CMD_WALK;
          lvl_c  = 2'd2;
        end else begin
          kind_c = fbm_pkg::CMD_BEYOND;
        end
      end
      fbm_pkg::ACT_ROOT: begin
        if (s1_item_r.pointer_slot < 4'(fbm_pkg::ROOT_COUNT)) begin
          kind_c = fbm_pkg::CMD_ROOT;
        end
      end
      fbm_pkg::ACT_FILL: begin
        if (s1_item_r.table_slot < 3'(fbm_pkg::TABLE_SLOTS)) begin
          kind_c = fbm_pkg::CMD_FILL;
        end
      end
      default: kind_c = fbm_pkg::CMD_NONE;
    endcase
  end

  // stage two: offset into the tree and per level table indices
  always_comb begin
    case (s2_lvl_r)
      2'd0:    base2 = 32'(fbm_pkg::DIRECT_POINTERS);
      2'd1:    base2 = fbm_pkg::fbm_span_end(bsl, 2'd0);
      default: base2 = fbm_pkg::fbm_span_end(bsl, 2'd1);
    endcase
    off = s2_item_r.logical_block - base2;
    case (bsl)
      2'd0: begin
        sh1  = off >> 8;
        sh2  = off >> 16;
        mask = 10'h0ff;
      end
      2'd1: begin
        sh1  = off >> 9;
        sh2  = off >> 18;
        mask = 10'h1ff;
      end
      default: begin
        sh1  = off >> 10;
        sh2  = off >> 20;
        mask = 10'h3ff;
      end
    endcase
    cmd             = '0;
    cmd.kind        = s2_kind_r;
    cmd.table_slot  = s2_item_r.table_slot;
    cmd.word_index  = s2_item_r.word_index;
    cmd.word_value  = s2_item_r.word_value;
    cmd.table_block = s2_item_r.table_block;
    cmd.fill_last   = s2_item_r.fill_last;
    case (s2_kind_r)
      fbm_pkg::CMD_ROOT:   cmd.sel = s2_item_r.pointer_slot;
      fbm_pkg::CMD_DIRECT: cmd.sel = s2_item_r.logical_block[3:0];
      fbm_pkg::CMD_WALK: begin
        cmd.sel = 4'(fbm_pkg::DIRECT_POINTERS) + {2'b00, s2_lvl_r};
        case (s2_lvl_r)
          2'd0: begin
            cmd.base   = 3'd0;
            cmd.levels = 2'd1;
            cmd.idx[0] = off[9:0] & mask;
          end
          2'd1: begin
            cmd.base   = 3'd1;
            cmd.levels = 2'd2;
            cmd.idx[0] = sh1[9:0] & mask;
            cmd.idx[1] = off[9:0] & mask;
          end
          default: begin
            cmd.base   = 3'd3;
            cmd.levels = 2'd3;
            cmd.idx[0] = sh2[9:0] & mask;
            cmd.idx[1] = sh1[9:0] & mask;
            cmd.idx[2] = off[9:0] & mask;
          end
        endcase
      end
      default: cmd.sel = 4'd0;
    endcase
  end

  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_item_r <= in_data;
    end
    if (s2_en) begin
      s2_item_r <= s1_item_r;
      s2_kind_r <= kind_c;
      s2_lvl_r  <= lvl_c;
    end
  end

endmodule

### design/fbm_queue.sv
// ----------------------------------------------------------------------------
// fbm_queue
// Small command queue between the classifier and the table walker.
// ----------------------------------------------------------------------------
module fbm_queue #(
  parameter int DEPTH = fbm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fbm_pkg::cmd_t   push_data,
  output logic            full,
  output logic            valid,
  output fbm_pkg::cmd_t   head,
  input  logic            pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fbm_pkg::cmd_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            do_pop;

  assign full   = (count_r == CW'(DEPTH));
  assign valid  = (count_r != '0);
  assign head   = entry_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/fbm_back.sv
// ----------------------------------------------------------------------------
// fbm_back
// Root pointers, table tags and the table store; executes commands and walks
// the indirect tables one synchronous read per level.
// ----------------------------------------------------------------------------
module fbm_back #(
  parameter int TABLE_WORDS = fbm_pkg::TABLE_WORDS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  fbm_pkg::cmd_t   q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output fbm_pkg::res_t   out_data
);

  localparam int AW        = $clog2(TABLE_WORDS);
  localparam int MEM_DEPTH = fbm_pkg::TABLE_SLOTS * TABLE_WORDS;
  localparam int MAW       = AW + 3;

  fbm_pkg::bk_state_t state_r;
  fbm_pkg::bk_state_t state_nxt;
  fbm_pkg::cmd_t      cur_r;
  fbm_pkg::cmd_t      cur_nxt;
  logic [31:0]        ptr_r;
  logic [31:0]        ptr_nxt;
  logic [1:0]         lvl_r;
  logic [1:0]         lvl_nxt;
  logic [2:0]         slot_r;
  logic [2:0]         slot_nxt;

  logic [31:0]        roots_r [fbm_pkg::ROOT_COUNT];
  logic [31:0]        tags_r  [fbm_pkg::TABLE_SLOTS];
  logic [31:0]        mem     [MEM_DEPTH];
  logic [31:0]        rdata_r;

  logic               out_v_r;
  fbm_pkg::res_t      out_r;

  logic               out_free;
  logic               emit;
  fbm_pkg::res_t      res;
  logic               root_we;
  logic               tag_we;
  logic               mem_we;
  logic               mem_rd;
  logic [MAW-1:0]     mem_waddr;
  logic [MAW-1:0]     mem_raddr;
  logic [31:0]        root_val;
  logic [9:0]         cur_idx;

  assign out_free  = !out_v_r || !out_stall;
  assign root_val  = roots_r[q_head.sel];
  assign mem_waddr = {q_head.table_slot, q_head.word_index[AW-1:0]};
  assign mem_raddr = {slot_r, cur_idx[AW-1:0]};

  always_comb begin
    case (lvl_r)
      2'd0:    cur_idx = cur_r.idx[0];
      2'd1:    cur_idx = cur_r.idx[1];
      default: cur_idx = cur_r.idx[2];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    ptr_nxt   = ptr_r;
    lvl_nxt   = lvl_r;
    slot_nxt  = slot_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    res       = '0;
    root_we   = 1'b0;
    tag_we    = 1'b0;
    mem_we    = 1'b0;
    mem_rd    = 1'b0;
    case (state_r)
      fbm_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            fbm_pkg::CMD_ROOT: begin
              root_we = 1'b1;
              q_pop   = 1'b1;
            end
            fbm_pkg::CMD_FILL: begin
              mem_we = 1'b1;
              tag_we = q_head.fill_last;
              q_pop  = 1'b1;
            end
            fbm_pkg::CMD_BEYOND: begin
              if (out_free) begin
                emit       = 1'b1;
                res.status = fbm_pkg::ST_BEYOND;
                q_pop      = 1'b1;
              end
            end
            fbm_pkg::CMD_DIRECT: begin
              if (out_free) begin
                emit  = 1'b1;
                q_pop = 1'b1;
                if (root_val == 32'd0) begin
                  res.status = fbm_pkg::ST_HOLE;
                end else begin
                  res.status       = fbm_pkg::ST_MAPPED;
                  res.block_number = root_val;
                end
              end
            end
            fbm_pkg::CMD_WALK: begin
              q_pop     = 1'b1;
              cur_nxt   = q_head;
              ptr_nxt   = root_val;
              lvl_nxt   = 2'd0;
              slot_nxt  = q_head.base;
              state_nxt = fbm_pkg::BK_CHECK;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      fbm_pkg::BK_CHECK: begin
        if (lvl_r == cur_r.levels) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = fbm_pkg::BK_IDLE;
            if (ptr_r == 32'd0) begin
              res.status = fbm_pkg::ST_HOLE;
            end else begin
              res.status       = fbm_pkg::ST_MAPPED;
              res.block_number = ptr_r;
            end
          end
        end else if (ptr_r == 32'd0) begin
          if (out_free) begin
            emit       = 1'b1;
            res.status = fbm_pkg::ST_HOLE;
            state_nxt  = fbm_pkg::BK_IDLE;
          end
        end else if (tags_r[slot_r] != ptr_r) begin
          if (out_free) begin
            emit                 = 1'b1;
            res.status           = fbm_pkg::ST_FETCH;
            res.block_number     = ptr_r;
            res.fetch_table_slot = slot_r;
            state_nxt            = fbm_pkg::BK_IDLE;
          end
        end else begin
          mem_rd    = 1'b1;
          state_nxt = fbm_pkg::BK_READ;
        end
      end
      fbm_pkg::BK_READ: begin
        ptr_nxt   = rdata_r;
        lvl_nxt   = lvl_r + 2'd1;
        slot_nxt  = slot_r + 3'd1;
        state_nxt = fbm_pkg::BK_CHECK;
      end
      default: state_nxt = fbm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbm_pkg::BK_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ptr_r  <= ptr_nxt;
    lvl_r  <= lvl_nxt;
    slot_r <= slot_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fbm_pkg::ROOT_COUNT; i++) begin
        roots_r[i] <= '0;
      end
      for (int i = 0; i < fbm_pkg::TABLE_SLOTS; i++) begin
        tags_r[i] <= '0;
      end
    end else begin
      if (root_we) begin
        roots_r[q_head.sel] <= q_head.word_value;
      end
      if (tag_we) begin
        tags_r[q_head.table_slot] <= q_head.table_block;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_head.word_value;
    end
    if (mem_rd) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
